@@ rtl/lsa_pkg.sv @@
// Package for the local sequence alignment block: sizes, codes and transaction types.
// No dependencies; used by local_sequence_alignment.
package lsa_pkg;

  localparam int unsigned MAX_LEN     = 32;
  localparam int unsigned GRID        = MAX_LEN + 1;
  localparam int unsigned DIR_DEPTH   = GRID * GRID;
  localparam int unsigned TRACE_DEPTH = 64;

  localparam int unsigned LEN_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned SEQ_AW   = $clog2(MAX_LEN);
  localparam int unsigned DIR_AW   = $clog2(DIR_DEPTH);
  localparam int unsigned TR_AW    = $clog2(TRACE_DEPTH);
  localparam int unsigned TR_CNT_W = $clog2(TRACE_DEPTH + 1);

  localparam int unsigned SCORE_W = 15;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned PADDR_W = 4;

  localparam logic [SYM_W-1:0] GAP_SYMBOL = 8'd45;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  localparam logic [1:0] DIR_DIAG = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_SELF = 2'd3;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]   aligned_a;
    logic [SYM_W-1:0]   aligned_b;
    logic [SCORE_W-1:0] best_score;
    logic               empty_alignment;
    logic               last_column;
  } out_item_t;

endpackage

@@ rtl/lsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/local_sequence_alignment.sv @@
// Top level of the local sequence alignment block: load, matrix fill, traceback, emit.
// Depends on lsa_pkg and lsa_ram.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | lsa_pkg::in_item_t
//  out     | output    | out_valid_o / out_stall_i | lsa_pkg::out_item_t
//  cfg     | input     | APB psel/penable/pwrite | 9-bit scores at 0x0, 0x4, 0x8
//
// Loads are taken while idle. A run fills the matrix through the
// score row RAM and direction RAM (one cell per cycle, one bubble per row),
// then traces back with a read and an evaluation per step and emits the result columns.
// No clearing pass after reset; reset clears lengths, the output register and control.
// in_stall_o is high for the whole run; out_stall_i holds the output register.
module local_sequence_alignment (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lsa_pkg::in_item_t      in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output lsa_pkg::out_item_t     out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [lsa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import lsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROW, ST_FILL, ST_DRAIN, ST_TR_INIT, ST_TR_RD, ST_TR_EV, ST_EMIT
  } state_e;

  typedef enum logic [1:0] { EM_RD, EM_WAIT, EM_EMPTY } emit_e;

  state_e state_q, state_d;
  emit_e  emit_q, emit_d;

  logic [CFG_W-1:0] match_q, mismatch_q, gap_q;
  logic [LEN_W-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic [LEN_W-1:0] i_q, i_d, j_q, j_d;
  logic [DIR_AW-1:0] row_base_q, row_base_d;
  logic             s1_v_q, s1_v_d, s1_frow_q, s1_frow_d;
  logic [LEN_W-1:0] s1_i_q, s1_i_d, s1_j_q, s1_j_d;
  logic [DIR_AW-1:0] s1_addr_q, s1_addr_d;
  logic [SCORE_W-1:0] diag_q, diag_d, left_q, left_d, best_q, best_d;
  logic [DIR_AW-1:0] baddr_q, baddr_d, taddr_q, taddr_d;
  logic [LEN_W-1:0] bi_q, bi_d, bj_q, bj_d, ci_q, ci_d, cj_q, cj_d;
  logic [TR_CNT_W-1:0] n_q, n_d;
  logic [TR_AW-1:0] k_q, k_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic                sa_we, sa_re, sb_we, sb_re, rw_we, rw_re, dr_we, dr_re, tb_we, tb_re;
  logic [SEQ_AW-1:0]   sa_waddr, sa_raddr, sb_waddr, sb_raddr, rw_waddr, rw_raddr;
  logic [SYM_W-1:0]    sa_rdata, sb_rdata;
  logic [SCORE_W-1:0]  rw_wdata, rw_rdata;
  logic [DIR_AW-1:0]   dr_waddr, dr_raddr;
  logic [1:0]          dr_wdata, dr_rdata;
  logic [TR_AW-1:0]    tb_waddr, tb_raddr;
  logic [2*SYM_W-1:0]  tb_wdata, tb_rdata;

  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  logic                out_free;

  logic [CFG_W-1:0]    sub;
  logic [SCORE_W-1:0]  diag_v, up_v, left_v;
  logic signed [15:0]  sum_d, sum_u, sum_l, m_s;
  logic [1:0]          m_dir;
  logic                mv_i, mv_j, tr_stop;

  function automatic logic signed [15:0] sat_add(logic [SCORE_W-1:0] a, logic [CFG_W-1:0] b);
    logic signed [16:0] s;
    s = $signed({2'b00, a}) + $signed({{(17-CFG_W){b[CFG_W-1]}}, b});
    if (s > 17'sd32767) begin
      return 16'sd32767;
    end
    return s[15:0];
  endfunction

  lsa_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seq_a (
    .clk_i, .we_i(sa_we), .waddr_i(sa_waddr), .wdata_i(in_data_i.symbol),
    .re_i(sa_re), .raddr_i(sa_raddr), .rdata_o(sa_rdata)
  );
  lsa_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seq_b (
    .clk_i, .we_i(sb_we), .waddr_i(sb_waddr), .wdata_i(in_data_i.symbol),
    .re_i(sb_re), .raddr_i(sb_raddr), .rdata_o(sb_rdata)
  );
  lsa_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN)) u_row (
    .clk_i, .we_i(rw_we), .waddr_i(rw_waddr), .wdata_i(rw_wdata),
    .re_i(rw_re), .raddr_i(rw_raddr), .rdata_o(rw_rdata)
  );
  lsa_ram #(.WIDTH(2), .DEPTH(DIR_DEPTH)) u_dir (
    .clk_i, .we_i(dr_we), .waddr_i(dr_waddr), .wdata_i(dr_wdata),
    .re_i(dr_re), .raddr_i(dr_raddr), .rdata_o(dr_rdata)
  );
  lsa_ram #(.WIDTH(2*SYM_W), .DEPTH(TRACE_DEPTH)) u_trace (
    .clk_i, .we_i(tb_we), .waddr_i(tb_waddr), .wdata_i(tb_wdata),
    .re_i(tb_re), .raddr_i(tb_raddr), .rdata_o(tb_rdata)
  );

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_MATCH:    prdata = {{(32-CFG_W){match_q[CFG_W-1]}}, match_q};
      REG_MISMATCH: prdata = {{(32-CFG_W){mismatch_q[CFG_W-1]}}, mismatch_q};
      REG_GAP:      prdata = {{(32-CFG_W){gap_q[CFG_W-1]}}, gap_q};
      default:      prdata = '0;
    endcase
  end

  // fill stage 1: cell score
  always_comb begin
    sub    = (sa_rdata == sb_rdata) ? match_q : mismatch_q;
    diag_v = (s1_j_q == LEN_W'(1)) ? '0 : diag_q;
    left_v = (s1_j_q == LEN_W'(1)) ? '0 : left_q;
    up_v   = s1_frow_q ? '0 : rw_rdata;
    sum_d  = sat_add(diag_v, sub);
    sum_u  = sat_add(up_v, gap_q);
    sum_l  = sat_add(left_v, gap_q);
    m_s    = sum_d;
    m_dir  = DIR_DIAG;
    if (sum_u > m_s) begin
      m_s   = sum_u;
      m_dir = DIR_UP;
    end
    if (sum_l > m_s) begin
      m_s   = sum_l;
      m_dir = DIR_LEFT;
    end
    if (m_s < 16'sd0) begin
      m_s   = 16'sd0;
      m_dir = DIR_SELF;
    end
  end

  assign mv_i    = (dr_rdata == DIR_DIAG) || (dr_rdata == DIR_UP);
  assign mv_j    = (dr_rdata == DIR_DIAG) || (dr_rdata == DIR_LEFT);
  assign tr_stop = (dr_rdata == DIR_SELF) || (mv_i && ci_q == LEN_W'(1)) ||
                   (mv_j && cj_q == LEN_W'(1)) || (n_q >= TR_CNT_W'(TRACE_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;  emit_d = emit_q;
    len_a_d = len_a_q;  len_b_d = len_b_q;
    i_d = i_q;  j_d = j_q;  row_base_d = row_base_q;
    s1_v_d = 1'b0;  s1_frow_d = s1_frow_q;
    s1_i_d = s1_i_q;  s1_j_d = s1_j_q;  s1_addr_d = s1_addr_q;
    diag_d = diag_q;  left_d = left_q;  best_d = best_q;
    baddr_d = baddr_q;  bi_d = bi_q;  bj_d = bj_q;
    taddr_d = taddr_q;  ci_d = ci_q;  cj_d = cj_q;
    n_d = n_q;  k_d = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;

    sa_we = 1'b0;  sa_waddr = len_a_q[SEQ_AW-1:0];
    sb_we = 1'b0;  sb_waddr = len_b_q[SEQ_AW-1:0];
    sa_re = 1'b0;  sa_raddr = '0;
    sb_re = 1'b0;  sb_raddr = '0;
    rw_re = 1'b0;  rw_raddr = '0;
    dr_re = 1'b0;  dr_raddr = taddr_q;
    tb_we = 1'b0;  tb_waddr = n_q[TR_AW-1:0];
    tb_wdata = {(mv_i ? sa_rdata : GAP_SYMBOL), (mv_j ? sb_rdata : GAP_SYMBOL)};
    tb_re = 1'b0;  tb_raddr = k_q;

    rw_we    = s1_v_q;
    rw_waddr = SEQ_AW'(s1_j_q - LEN_W'(1));
    rw_wdata = m_s[SCORE_W-1:0];
    dr_we    = s1_v_q;
    dr_waddr = s1_addr_q;
    dr_wdata = m_dir;
    if (s1_v_q) begin
      diag_d = up_v;
      left_d = m_s[SCORE_W-1:0];
      if (m_s[SCORE_W-1:0] > best_q) begin
        best_d  = m_s[SCORE_W-1:0];
        baddr_d = s1_addr_q;
        bi_d    = s1_i_q;
        bj_d    = s1_j_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.mode)
            MODE_LOAD_A: begin
              if (len_a_q < LEN_W'(MAX_LEN)) begin
                sa_we   = 1'b1;
                len_a_d = len_a_q + LEN_W'(1);
              end
            end
            MODE_LOAD_B: begin
              if (len_b_q < LEN_W'(MAX_LEN)) begin
                sb_we   = 1'b1;
                len_b_d = len_b_q + LEN_W'(1);
              end
            end
            MODE_RUN: begin
              best_d = '0;  baddr_d = '0;  bi_d = '0;  bj_d = '0;
              i_d = LEN_W'(1);
              row_base_d = DIR_AW'(GRID);
              if (len_a_q == '0 || len_b_q == '0) begin
                state_d = ST_TR_INIT;
              end else begin
                state_d = ST_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROW: begin
        sa_re    = 1'b1;
        sa_raddr = SEQ_AW'(i_q - LEN_W'(1));
        j_d      = LEN_W'(1);
        state_d  = ST_FILL;
      end
      ST_FILL: begin
        rw_re     = 1'b1;
        rw_raddr  = SEQ_AW'(j_q - LEN_W'(1));
        sb_re     = 1'b1;
        sb_raddr  = SEQ_AW'(j_q - LEN_W'(1));
        s1_v_d    = 1'b1;
        s1_i_d    = i_q;
        s1_j_d    = j_q;
        s1_frow_d = (i_q == LEN_W'(1));
        s1_addr_d = row_base_q + DIR_AW'(j_q);
        if (j_q == len_b_q) begin
          if (i_q == len_a_q) begin
            state_d = ST_DRAIN;
          end else begin
            i_d        = i_q + LEN_W'(1);
            row_base_d = row_base_q + DIR_AW'(GRID);
            state_d    = ST_ROW;
          end
        end else begin
          j_d = j_q + LEN_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_TR_INIT;
      end
      ST_TR_INIT: begin
        ci_d = bi_q;  cj_d = bj_q;  taddr_d = baddr_q;  n_d = '0;
        len_a_d = '0;  len_b_d = '0;
        if (best_q == '0) begin
          emit_d  = EM_EMPTY;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_TR_RD;
        end
      end
      ST_TR_RD: begin
        dr_re    = 1'b1;
        sa_re    = 1'b1;
        sa_raddr = SEQ_AW'(ci_q - LEN_W'(1));
        sb_re    = 1'b1;
        sb_raddr = SEQ_AW'(cj_q - LEN_W'(1));
        state_d  = ST_TR_EV;
      end
      ST_TR_EV: begin
        if (tr_stop) begin
          state_d = ST_EMIT;
          if (n_q == '0) begin
            emit_d = EM_EMPTY;
          end else begin
            emit_d = EM_RD;
            k_d    = TR_AW'(n_q - TR_CNT_W'(1));
          end
        end else begin
          tb_we = 1'b1;
          n_d   = n_q + TR_CNT_W'(1);
          if (mv_i) begin
            ci_d = ci_q - LEN_W'(1);
          end
          if (mv_j) begin
            cj_d = cj_q - LEN_W'(1);
          end
          taddr_d = taddr_q - (mv_i ? DIR_AW'(GRID) : '0) - (mv_j ? DIR_AW'(1) : '0);
          state_d = ST_TR_RD;
        end
      end
      ST_EMIT: begin
        unique case (emit_q)
          EM_RD: begin
            tb_re  = 1'b1;
            emit_d = EM_WAIT;
          end
          EM_WAIT: begin
            if (out_free) begin
              out_valid_d           = 1'b1;
              out_d.aligned_a       = tb_rdata[2*SYM_W-1:SYM_W];
              out_d.aligned_b       = tb_rdata[SYM_W-1:0];
              out_d.best_score      = best_q;
              out_d.empty_alignment = 1'b0;
              out_d.last_column     = (k_q == '0);
              if (k_q == '0) begin
                state_d = ST_IDLE;
              end else begin
                k_d    = k_q - TR_AW'(1);
                emit_d = EM_RD;
              end
            end
          end
          EM_EMPTY: begin
            if (out_free) begin
              out_valid_d           = 1'b1;
              out_d.aligned_a       = '0;
              out_d.aligned_b       = '0;
              out_d.best_score      = best_q;
              out_d.empty_alignment = 1'b1;
              out_d.last_column     = 1'b1;
              state_d               = ST_IDLE;
            end
          end
          default: emit_d = EM_RD;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      emit_q      <= EM_RD;
      match_q     <= 9'sd3;
      mismatch_q  <= -9'sd3;
      gap_q       <= -9'sd2;
      len_a_q     <= '0;
      len_b_q     <= '0;
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      s1_v_q      <= s1_v_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_MATCH:    match_q    <= pwdata[CFG_W-1:0];
          REG_MISMATCH: mismatch_q <= pwdata[CFG_W-1:0];
          REG_GAP:      gap_q      <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    row_base_q <= row_base_d;
    s1_frow_q  <= s1_frow_d;
    s1_i_q     <= s1_i_d;
    s1_j_q     <= s1_j_d;
    s1_addr_q  <= s1_addr_d;
    diag_q     <= diag_d;
    left_q     <= left_d;
    best_q     <= best_d;
    baddr_q    <= baddr_d;
    bi_q       <= bi_d;
    bj_q       <= bj_d;
    taddr_q    <= taddr_d;
    ci_q       <= ci_d;
    cj_q       <= cj_d;
    n_q        <= n_d;
    k_q        <= k_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/local_sequence_alignment_test.sv @@
// Testbench for local_sequence_alignment: loads sequences, runs alignments and checks
// every emitted column against an in-bench scoring and traceback predictor.
// Depends on lsa_pkg and the local_sequence_alignment RTL.
module local_sequence_alignment_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lsa_pkg::*;

  localparam int LIMIT = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #6 clk_i = ~clk_i;

  local_sequence_alignment u_dut (.*);

  // predictor state
  int match_val, mismatch_val, gap_val;
  logic [7:0] seq_a[MAX_LEN], seq_b[MAX_LEN];
  int len_a, len_b;
  out_item_t column_queue[$];
  int errors = 0;
  int cycles = 0;
  bit stall_rand = 1'b1;

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int sx9(logic [8:0] v);
    return int'(signed'(v));
  endfunction

  task automatic predict_item(in_item_t it);
    int score[GRID][GRID];
    logic [1:0] dir[GRID][GRID];
    int best, bi, bj, ci, cj, ni, nj, n, d, u, l, m;
    logic [7:0] ta[TRACE_DEPTH], tb[TRACE_DEPTH];
    out_item_t o;
    if (it.mode == MODE_LOAD_A) begin
      if (len_a < MAX_LEN) begin seq_a[len_a] = it.symbol; len_a++; end
    end else if (it.mode == MODE_LOAD_B) begin
      if (len_b < MAX_LEN) begin seq_b[len_b] = it.symbol; len_b++; end
    end else if (it.mode == MODE_RUN) begin
      for (int i = 0; i <= len_a; i++) begin score[i][0] = 0; dir[i][0] = DIR_SELF; end
      for (int j = 0; j <= len_b; j++) begin score[0][j] = 0; dir[0][j] = DIR_SELF; end
      for (int i = 1; i <= len_a; i++)
        for (int j = 1; j <= len_b; j++) begin
          d = sat16(score[i-1][j-1] + ((seq_a[i-1] == seq_b[j-1]) ? match_val : mismatch_val));
          u = sat16(score[i-1][j] + gap_val);
          l = sat16(score[i][j-1] + gap_val);
          m = d; dir[i][j] = DIR_DIAG;
          if (u > m) begin m = u; dir[i][j] = DIR_UP; end
          if (l > m) begin m = l; dir[i][j] = DIR_LEFT; end
          if (0 > m) begin m = 0; dir[i][j] = DIR_SELF; end
          score[i][j] = m;
        end
      best = -1; bi = 0; bj = 0;
      for (int i = 0; i <= len_a; i++)
        for (int j = 0; j <= len_b; j++)
          if (score[i][j] > best) begin best = score[i][j]; bi = i; bj = j; end
      ci = bi; cj = bj; n = 0;
      forever begin
        ni = (dir[ci][cj] == DIR_DIAG || dir[ci][cj] == DIR_UP) ? ci - 1 : ci;
        nj = (dir[ci][cj] == DIR_DIAG || dir[ci][cj] == DIR_LEFT) ? cj - 1 : cj;
        if (dir[ci][cj] == DIR_SELF || ni == 0 || nj == 0 || n >= TRACE_DEPTH) break;
        ta[n] = (ni == ci) ? GAP_SYMBOL : seq_a[ci-1];
        tb[n] = (nj == cj) ? GAP_SYMBOL : seq_b[cj-1];
        n++; ci = ni; cj = nj;
      end
      len_a = 0; len_b = 0;
      if (n == 0) begin
        o = '0; o.best_score = best[14:0]; o.empty_alignment = 1'b1; o.last_column = 1'b1;
        column_queue.push_back(o);
      end else
        for (int k = 0; k < n; k++) begin
          o.aligned_a = ta[n-1-k]; o.aligned_b = tb[n-1-k];
          o.best_score = best[14:0]; o.empty_alignment = 1'b0;
          o.last_column = (k == n - 1);
          column_queue.push_back(o);
        end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(idx) << 2; pwdata <= 32'(val) & 32'h1FF;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MATCH: match_val = sx9(9'(val));
      REG_MISMATCH: mismatch_val = sx9(9'(val));
      default: gap_val = sx9(9'(val));
    endcase
  endtask

  task automatic send_item(in_item_t it, bit use_model = 1'b1);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (use_model) predict_item(it);
    @(negedge clk_i);
  endtask

  task automatic drain_runs();
    while (column_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // random burst sender
  int burst = 0;
  task automatic send_burst(in_item_t it);
    if (burst == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst = $urandom_range(1, 12);
    end
    burst--;
    send_item(it);
  endtask

  task automatic send_random_sequence();
    in_item_t it;
    int na, nb, alpha;
    alpha = $urandom_range(0, 3) == 0 ? 256 : $urandom_range(2, 5);
    na = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
    nb = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
    for (int k = 0; k < na + nb; k++) begin
      it.mode = (k < na) ? MODE_LOAD_A : MODE_LOAD_B;
      if ($urandom_range(0, 15) == 0) it.mode = 2'd3;
      it.symbol = (alpha == 256) ? 8'($urandom) : 8'(65 + $urandom_range(0, alpha - 1));
      send_burst(it);
    end
    it.mode = MODE_RUN; it.symbol = 8'($urandom);
    send_burst(it);
  endtask

  // directed table: mode, symbol
  in_item_t directed[] = '{
    '{MODE_RUN, 8'h00},
    '{MODE_LOAD_A, 8'h00}, '{MODE_LOAD_A, 8'hFF}, '{MODE_LOAD_A, 8'h41},
    '{MODE_LOAD_B, 8'hFF}, '{MODE_LOAD_B, 8'h41}, '{2'd3, 8'hAA},
    '{MODE_RUN, 8'hFF},
    '{MODE_LOAD_A, 8'h55}, '{MODE_LOAD_B, 8'hAA}, '{MODE_RUN, 8'h55},
    '{MODE_LOAD_A, 8'h41}, '{MODE_LOAD_A, 8'h43}, '{MODE_LOAD_A, 8'h47},
    '{MODE_LOAD_B, 8'h41}, '{MODE_LOAD_B, 8'h47}, '{MODE_RUN, 8'h00}
  };

  // receiver and checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (column_queue.size() == 0) begin
        $display("%0t: unexpected column %p", $realtime, out_data_o);
        errors++;
      end else begin
        out_item_t want;
        want = column_queue.pop_front();
        if (want !== out_data_o) begin
          $display("%0t: expected %p, actual %p", $realtime, want, out_data_o);
          errors++;
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_stall_i <= stall_rand ? (($urandom_range(0, 3) == 0) || (cycles[9:7] == 3'd5)) : 1'b0;

  initial begin
    in_item_t it;
    match_val = 3; mismatch_val = -3; gap_val = -2;
    len_a = 0; len_b = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // after reset nothing is loaded: empty alignment, score zero
    column_queue.push_back('{8'd0, 8'd0, 15'd0, 1'b1, 1'b1});
    it = directed[0];
    send_item(it, 1'b0);
    in_valid_i <= 1'b0;
    drain_runs();
    for (int r = 1; r < directed.size(); r++) send_item(directed[r]);
    in_valid_i <= 1'b0;
    drain_runs();
    // sign extremes of the scores, full sequence overflow
    write_reg(REG_MATCH, 255); write_reg(REG_MISMATCH, -256); write_reg(REG_GAP, 255);
    for (int k = 0; k < 34; k++) begin it.mode = MODE_LOAD_A; it.symbol = 8'h41; send_item(it); end
    for (int k = 0; k < 34; k++) begin it.mode = MODE_LOAD_B; it.symbol = 8'h41; send_item(it); end
    it.mode = MODE_RUN; send_item(it);
    in_valid_i <= 1'b0;
    drain_runs();
    write_reg(REG_MATCH, -256); write_reg(REG_MISMATCH, 255); write_reg(REG_GAP, -256);
    for (int phase = 0; phase < 6; phase++) begin
      stall_rand = (phase != 2);
      send_random_sequence();
      in_valid_i <= 1'b0;
      drain_runs();
      write_reg(REG_MATCH, $urandom_range(1, 8));
      write_reg(REG_MISMATCH, -int'($urandom_range(0, 8)));
      write_reg(REG_GAP, (phase == 4) ? 0 : -int'($urandom_range(1, 6)));
    end
    write_reg(REG_MATCH, 3); write_reg(REG_MISMATCH, -3); write_reg(REG_GAP, -2);
    for (int s = 0; s < 2; s++) send_random_sequence();
    in_valid_i <= 1'b0;
    drain_runs();
    if (errors == 0 && column_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ local_sequence_alignment.f @@
rtl/lsa_pkg.sv
rtl/lsa_ram.sv
rtl/local_sequence_alignment.sv
verif/local_sequence_alignment_test.sv
